// File: hw/rtl/step_sequencer_playhead_macros.svh
// Assertion macros shared by the step sequencer checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef STEP_SEQUENCER_PLAYHEAD_MACROS_SVH
`define STEP_SEQUENCER_PLAYHEAD_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSPL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SSPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sspl_pkg.sv
// Shared types, codes and constants of the step sequencer playhead.
// No dependencies; used by step_sequencer_playhead and sspl_advance.
`timescale 1ns / 1ps
`default_nettype none

package sspl_pkg;

  localparam int unsigned MAX_STEPS_DEF = 64;
  localparam int unsigned PH_LIMIT      = 64;
  localparam int unsigned ENTRY_W       = 16;

  localparam logic [7:0] STATUS_BASE = 8'd143;

  // Register reset values
  localparam logic [6:0] STEP_COUNT_RST   = 7'd16;
  localparam logic [7:0] CLOCK_DIVIDE_RST = 8'd1;
  localparam logic [7:0] TRANSPOSE_RST    = 8'd0;
  localparam logic [4:0] MIDI_CHANNEL_RST = 5'd1;
  localparam logic [5:0] LOOP_START_RST   = 6'd0;
  localparam logic [5:0] LOOP_STOP_RST    = 6'd15;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_WRITE     = 3'd1,
    CMD_SET_QUEUE = 3'd2,
    CMD_RESET_PH  = 3'd3,
    CMD_SET_MUTE  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    REG_STEP_COUNT   = 3'd0,
    REG_CLOCK_DIVIDE = 3'd1,
    REG_TRANSPOSE    = 3'd2,
    REG_MIDI_CHANNEL = 3'd3,
    REG_DIRECTION    = 3'd4,
    REG_LOOP_START   = 3'd5,
    REG_LOOP_STOP    = 3'd6
  } reg_e;

  typedef enum logic [1:0] {
    DIR_FWD    = 2'd0,
    DIR_BWD    = 2'd1,
    DIR_BOUNCE = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    KIND_NULL = 2'd0,
    KIND_NOTE = 2'd1,
    KIND_CC   = 2'd2
  } kind_e;

  // Inputs of the playhead advance logic
  typedef struct packed {
    logic [5:0] pos;
    logic [5:0] loop_start;
    logic [5:0] loop_stop;
    logic [1:0] dir;
    logic [6:0] n;
    logic       bounce_up;
  } adv_in_t;

  // Result of one playhead advance
  typedef struct packed {
    logic [5:0] pos;
    logic       bounce_up;
  } adv_out_t;

endpackage

`default_nettype wire

// File: hw/rtl/step_sequencer_playhead.sv
// Step sequencer playhead: step table in RAM, playhead, divider and flags.
// Depends on sspl_pkg, sspl_ram and sspl_advance.
//
// Usage:
//   Commands arrive on the in_* valid/ready channel, one result per command
//   leaves on the out_* valid/ready channel. Configuration registers are
//   written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must do so
//   only while the block idles, which the block itself does not enforce. Each
//   command issues the step table read at its transfer edge (at the playhead
//   for a tick, at step_index otherwise); its commit edge, which waits until
//   the output register is free, applies the read-modify-write with the read
//   data back from the RAM and loads the output register. in_ready_o is high
//   only between commands, so a new command is taken only once the last one
//   has committed; running strictly one command at a time keeps a write step
//   and the following read ordered. out_valid_o rises at the commit edge.
//   When the receiver stalls, the result holds in the output register and a
//   new command is still taken; its update waits until the register frees.
//   Reset clears the playhead, divider, flags and per-step valid bits, so the
//   whole table reads as null steps at once; registers go to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module step_sequencer_playhead #(
  parameter int unsigned MAX_STEPS = sspl_pkg::MAX_STEPS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration write port
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [7:0] cfg_wdata_i,
  // command channel
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [2:0] cmd_i,
  input  wire logic [5:0] step_index_i,
  input  wire logic [1:0] trig_kind_i,
  input  wire logic [6:0] note_value_i,
  input  wire logic [6:0] note_velocity_i,
  input  wire logic       flag_value_i,
  // result channel
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            note_valid_o,
  output logic [7:0]      status_byte_o,
  output logic [6:0]      note_byte_o,
  output logic [6:0]      velocity_byte_o,
  output logic [5:0]      playhead_pos_o,
  output logic            playhead_moved_o,
  output logic            loop_done_o,
  output logic            muted_o,
  output logic            queued_o,
  output logic            activation_changed_o,
  output logic            step_active_o
);

  localparam int unsigned AW = $clog2(MAX_STEPS);
  localparam logic [8:0] DEPTH9 = 9'(MAX_STEPS);
  localparam logic [6:0] LIMIT =
      (MAX_STEPS < sspl_pkg::PH_LIMIT) ? 7'(MAX_STEPS) : 7'(sspl_pkg::PH_LIMIT);
  localparam int unsigned EW = sspl_pkg::ENTRY_W;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic        [6:0] step_count_q;
  logic        [7:0] clock_divide_q;
  logic signed [7:0] transpose_q;
  logic        [4:0] midi_channel_q;
  logic        [1:0] direction_q;
  logic        [5:0] loop_start_q;
  logic        [5:0] loop_stop_q;

  // sequencer state
  logic [5:0]           playhead_q, playhead_d;
  logic [7:0]           div_cnt_q, div_cnt_d;
  logic                 bounce_up_q, bounce_up_d;
  logic                 mute_q, mute_d;
  logic                 queue_q, queue_d;
  logic [MAX_STEPS-1:0] vld_q, vld_d;

  // captured command
  logic [2:0] cmd_q;
  logic [5:0] idx_q;
  logic [1:0] kind_q;
  logic [6:0] nval_q;
  logic [6:0] nvel_q;
  logic       flag_q;

  // read-side samples, aligned with the RAM read data
  logic ent_vld_q;
  logic idx_rng_q;

  // output register
  logic       out_valid_q, out_valid_d;
  logic       o_nv_q, o_nv_d;
  logic [7:0] o_st_q, o_st_d;
  logic [6:0] o_nb_q, o_nb_d;
  logic [6:0] o_vb_q, o_vb_d;
  logic       o_mv_q, o_mv_d;
  logic       o_dn_q, o_dn_d;
  logic       o_chg_q, o_chg_d;
  logic       o_act_q, o_act_d;

  logic          accept;
  logic          commit;
  logic [2:0]    rd_cmd;
  logic [5:0]    rd_step;
  logic [5:0]    rd_pos;
  logic          rd_in_rng;
  logic [AW-1:0] raddr;
  logic [EW-1:0] rdata;
  logic          ram_we;
  logic [EW-1:0] ram_wdata;

  logic [1:0]        ent_kind;
  logic [6:0]        sc_eff;
  logic [6:0]        n_eff;
  logic [7:0]        div_eff;
  logic [8:0]        div_inc;
  logic signed [8:0] note_sum;
  logic [6:0]        note_sat;
  logic              mute_now;

  sspl_pkg::adv_in_t  adv_in;
  sspl_pkg::adv_out_t adv_out;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign commit     = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  // Address the table from the incoming command while idle, from the
  // captured one afterwards; the read repeats while the result waits.
  always_comb begin
    rd_cmd    = (state_q == S_IDLE) ? cmd_i : cmd_q;
    rd_step   = (state_q == S_IDLE) ? step_index_i : idx_q;
    rd_pos    = (rd_cmd == sspl_pkg::CMD_TICK) ? playhead_q : rd_step;
    rd_in_rng = ({3'b000, rd_pos} < DEPTH9);
    raddr     = AW'(rd_pos);
  end

  assign ram_wdata = {kind_q, nval_q, nvel_q};

  sspl_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_STEPS)
  ) u_step_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(idx_q)),
    .wdata_i (ram_wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // entry never written, or beyond the table, reads as a null step
  assign ent_kind = ent_vld_q ? rdata[15:14] : sspl_pkg::KIND_NULL;

  always_comb begin
    sc_eff   = (step_count_q == 7'd0) ? 7'd1 : step_count_q;
    n_eff    = (sc_eff > LIMIT) ? LIMIT : sc_eff;
    div_eff  = (clock_divide_q == 8'd0) ? 8'd1 : clock_divide_q;
    div_inc  = {1'b0, div_cnt_q} + 9'd1;
    note_sum = $signed({2'b00, rdata[13:7]}) + $signed({transpose_q[7], transpose_q});
    if (note_sum < 0) begin
      note_sat = 7'd0;
    end else if (note_sum > 9'sd127) begin
      note_sat = 7'd127;
    end else begin
      note_sat = note_sum[6:0];
    end
    // apply a queued toggle at the subloop start before playing the step
    mute_now = (queue_q && (playhead_q == loop_start_q)) ? !mute_q : mute_q;
  end

  always_comb begin
    adv_in.pos        = playhead_q;
    adv_in.loop_start = loop_start_q;
    adv_in.loop_stop  = loop_stop_q;
    adv_in.dir        = direction_q;
    adv_in.n          = n_eff;
    adv_in.bounce_up  = bounce_up_q;
  end

  sspl_advance u_advance (
    .adv_i (adv_in),
    .adv_o (adv_out)
  );

  // read-modify-write of one command
  always_comb begin
    state_d     = state_q;
    playhead_d  = playhead_q;
    div_cnt_d   = div_cnt_q;
    bounce_up_d = bounce_up_q;
    mute_d      = mute_q;
    queue_d     = queue_q;
    vld_d       = vld_q;
    ram_we      = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    o_nv_d      = o_nv_q;
    o_st_d      = o_st_q;
    o_nb_d      = o_nb_q;
    o_vb_d      = o_vb_q;
    o_mv_d      = o_mv_q;
    o_dn_d      = o_dn_q;
    o_chg_d     = o_chg_q;
    o_act_d     = o_act_q;

    if (accept) begin
      state_d = S_EXEC;
    end

    if (commit) begin
      state_d     = S_IDLE;
      out_valid_d = 1'b1;
      o_nv_d      = 1'b0;
      o_st_d      = 8'd0;
      o_nb_d      = 7'd0;
      o_vb_d      = 7'd0;
      o_mv_d      = 1'b0;
      o_dn_d      = 1'b0;
      o_chg_d     = 1'b0;
      o_act_d     = 1'b0;
      case (cmd_q)
        sspl_pkg::CMD_TICK: begin
          if (div_cnt_q == 8'd0) begin
            if (queue_q && (playhead_q == loop_start_q)) begin
              queue_d = 1'b0;
            end
            mute_d = mute_now;
            if (!mute_now) begin
              if (ent_kind == sspl_pkg::KIND_NOTE) begin
                o_nv_d = 1'b1;
                o_st_d = sspl_pkg::STATUS_BASE + {3'b000, midi_channel_q};
                o_nb_d = note_sat;
                o_vb_d = rdata[6:0];
              end
              o_dn_d = (playhead_q == loop_stop_q);
            end
            playhead_d  = adv_out.pos;
            bounce_up_d = adv_out.bounce_up;
            o_mv_d      = 1'b1;
          end
          div_cnt_d = (div_inc >= {1'b0, div_eff}) ? 8'd0 : div_inc[7:0];
        end
        sspl_pkg::CMD_WRITE: begin
          if (idx_rng_q) begin
            ram_we  = 1'b1;
            vld_d[AW'(idx_q)] = 1'b1;
            o_chg_d = (ent_kind == sspl_pkg::KIND_NULL) != (kind_q == sspl_pkg::KIND_NULL);
            o_act_d = (kind_q != sspl_pkg::KIND_NULL);
          end
        end
        sspl_pkg::CMD_SET_QUEUE: begin
          queue_d = flag_q;
        end
        sspl_pkg::CMD_RESET_PH: begin
          playhead_d = loop_start_q;
          div_cnt_d  = 8'd0;
          o_mv_d     = 1'b1;
        end
        sspl_pkg::CMD_SET_MUTE: begin
          mute_d = flag_q;
        end
        default: begin
          // unknown command: report the state unchanged
          o_mv_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      step_count_q   <= sspl_pkg::STEP_COUNT_RST;
      clock_divide_q <= sspl_pkg::CLOCK_DIVIDE_RST;
      transpose_q    <= sspl_pkg::TRANSPOSE_RST;
      midi_channel_q <= sspl_pkg::MIDI_CHANNEL_RST;
      direction_q    <= sspl_pkg::DIR_FWD;
      loop_start_q   <= sspl_pkg::LOOP_START_RST;
      loop_stop_q    <= sspl_pkg::LOOP_STOP_RST;
      playhead_q     <= 6'd0;
      div_cnt_q      <= 8'd0;
      bounce_up_q    <= 1'b1;
      mute_q         <= 1'b0;
      queue_q        <= 1'b0;
      vld_q          <= '0;
      cmd_q          <= sspl_pkg::CMD_TICK;
      idx_q          <= 6'd0;
      kind_q         <= 2'd0;
      nval_q         <= 7'd0;
      nvel_q         <= 7'd0;
      flag_q         <= 1'b0;
      ent_vld_q      <= 1'b0;
      idx_rng_q      <= 1'b0;
      out_valid_q    <= 1'b0;
      o_nv_q         <= 1'b0;
      o_st_q         <= 8'd0;
      o_nb_q         <= 7'd0;
      o_vb_q         <= 7'd0;
      o_mv_q         <= 1'b0;
      o_dn_q         <= 1'b0;
      o_chg_q        <= 1'b0;
      o_act_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      playhead_q  <= playhead_d;
      div_cnt_q   <= div_cnt_d;
      bounce_up_q <= bounce_up_d;
      mute_q      <= mute_d;
      queue_q     <= queue_d;
      vld_q       <= vld_d;
      // sample the valid bit with the RAM read so both line up
      ent_vld_q   <= rd_in_rng && vld_q[raddr];
      idx_rng_q   <= rd_in_rng;
      out_valid_q <= out_valid_d;
      o_nv_q      <= o_nv_d;
      o_st_q      <= o_st_d;
      o_nb_q      <= o_nb_d;
      o_vb_q      <= o_vb_d;
      o_mv_q      <= o_mv_d;
      o_dn_q      <= o_dn_d;
      o_chg_q     <= o_chg_d;
      o_act_q     <= o_act_d;
      if (accept) begin
        cmd_q  <= cmd_i;
        idx_q  <= step_index_i;
        kind_q <= trig_kind_i;
        nval_q <= note_value_i;
        nvel_q <= note_velocity_i;
        flag_q <= flag_value_i;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sspl_pkg::REG_STEP_COUNT:   step_count_q   <= cfg_wdata_i[6:0];
          sspl_pkg::REG_CLOCK_DIVIDE: clock_divide_q <= cfg_wdata_i;
          sspl_pkg::REG_TRANSPOSE:    transpose_q    <= $signed(cfg_wdata_i);
          sspl_pkg::REG_MIDI_CHANNEL: midi_channel_q <= cfg_wdata_i[4:0];
          sspl_pkg::REG_DIRECTION:    direction_q    <= cfg_wdata_i[1:0];
          sspl_pkg::REG_LOOP_START:   loop_start_q   <= cfg_wdata_i[5:0];
          sspl_pkg::REG_LOOP_STOP:    loop_stop_q    <= cfg_wdata_i[5:0];
          default: begin
            // drop writes beyond the register list
            step_count_q <= step_count_q;
          end
        endcase
      end
    end
  end

  assign out_valid_o          = out_valid_q;
  assign note_valid_o         = o_nv_q;
  assign status_byte_o        = o_st_q;
  assign note_byte_o          = o_nb_q;
  assign velocity_byte_o      = o_vb_q;
  assign playhead_pos_o       = playhead_q;
  assign playhead_moved_o     = o_mv_q;
  assign loop_done_o          = o_dn_q;
  assign muted_o              = mute_q;
  assign queued_o             = queue_q;
  assign activation_changed_o = o_chg_q;
  assign step_active_o        = o_act_q;

endmodule

`default_nettype wire

// File: hw/rtl/sspl_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sspl_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/sspl_advance.sv
// Next playhead position and bounce direction for one divided tick.
// Depends on sspl_pkg for the direction codes and the advance structs.
`timescale 1ns / 1ps
`default_nettype none

module sspl_advance (
  input  wire sspl_pkg::adv_in_t  adv_i,
  output sspl_pkg::adv_out_t      adv_o
);

  logic [5:0] pos_inc;
  logic [5:0] pos_dec;
  logic [6:0] last;

  // wrap forward at the last step in use, backward from zero to it
  always_comb begin
    last    = adv_i.n - 7'd1;
    pos_inc = ({1'b0, adv_i.pos} >= last) ? 6'd0 : adv_i.pos + 6'd1;
    pos_dec = (adv_i.pos == 6'd0) ? last[5:0] : adv_i.pos - 6'd1;
  end

  always_comb begin
    adv_o.pos       = adv_i.pos;
    adv_o.bounce_up = adv_i.bounce_up;
    case (adv_i.dir)
      sspl_pkg::DIR_FWD: begin
        adv_o.pos = (adv_i.pos == adv_i.loop_stop) ? adv_i.loop_start : pos_inc;
      end
      sspl_pkg::DIR_BWD: begin
        adv_o.pos = (adv_i.pos == adv_i.loop_start) ? adv_i.loop_stop : pos_dec;
      end
      sspl_pkg::DIR_BOUNCE: begin
        if (adv_i.pos == adv_i.loop_stop) begin
          adv_o.pos       = pos_dec;
          adv_o.bounce_up = 1'b0;
        end else if (adv_i.pos == adv_i.loop_start) begin
          adv_o.pos       = pos_inc;
          adv_o.bounce_up = 1'b1;
        end else begin
          adv_o.pos = adv_i.bounce_up ? pos_inc : pos_dec;
        end
      end
      default: begin
        // undefined direction: hold position
        adv_o.pos = adv_i.pos;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/sspl_checker.sv
// Port-level checks of the step sequencer playhead, bound to the top level.
// Depends on step_sequencer_playhead_macros.svh and step_sequencer_playhead.
`timescale 1ns / 1ps
`default_nettype none
`include "step_sequencer_playhead_macros.svh"

module sspl_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       note_valid_o,
  input wire logic [7:0] status_byte_o,
  input wire logic [6:0] note_byte_o,
  input wire logic [6:0] velocity_byte_o,
  input wire logic [5:0] playhead_pos_o,
  input wire logic       playhead_moved_o,
  input wire logic       loop_done_o,
  input wire logic       muted_o,
  input wire logic       queued_o,
  input wire logic       activation_changed_o,
  input wire logic       step_active_o
);

  // a waiting result holds until its transfer
  `SSPL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i), (out_valid_o && $stable(playhead_pos_o) && $stable(muted_o) && $stable(queued_o) && $stable(note_byte_o)), "stalled result changed")

  // one command at a time: no transfer on the cycle after a transfer
  `SSPL_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, (in_valid_i && in_ready_o), (!in_ready_o), "input taken on back-to-back cycles")

  // note bytes are zero unless a note-on is emitted
  `SSPL_ASSERT_IMPL(a_quiet_bytes, clk_i, rst_ni, (out_valid_o && !note_valid_o), ((status_byte_o == 8'd0) && (note_byte_o == 7'd0) && (velocity_byte_o == 7'd0)), "note bytes set without note-on")

  // a played step comes from an unmuted divided tick
  `SSPL_ASSERT_IMPL(a_play_on_tick, clk_i, rst_ni, (out_valid_o && (note_valid_o || loop_done_o)), (playhead_moved_o && !muted_o), "step played without an unmuted tick")

  // step write reports never coincide with playhead motion
  `SSPL_ASSERT_IMPL(a_write_only, clk_i, rst_ni, (out_valid_o && (activation_changed_o || step_active_o)), (!playhead_moved_o && !note_valid_o), "write report mixed with playback")

endmodule

bind step_sequencer_playhead sspl_checker u_sspl_checker (.*);

`default_nettype wire
